/* rtl/sip_pkg.sv */
package sip_pkg;

	localparam int LON_W      = 31;
	localparam int LAT_W      = 30;
	localparam int PROD_W     = 63;
	localparam int CROSS_W    = 64;
	localparam int REM_W      = 63;
	localparam int QUO_W      = 32;
	localparam int DIV_STAGES = QUO_W;
	localparam int IN_DATA_W  = 248;
	localparam int OUT_DATA_W = 64;

	typedef struct packed {
		logic                    hit;
		logic                    neg_x;
		logic                    neg_y;
		logic signed [LON_W-1:0] p0_x;
		logic signed [LAT_W-1:0] p0_y;
		logic [REM_W-1:0]        den;
		logic [REM_W-1:0]        rem_x;
		logic [QUO_W-1:0]        low_x;
		logic [QUO_W-1:0]        quo_x;
		logic [REM_W-1:0]        rem_y;
		logic [QUO_W-1:0]        low_y;
		logic [QUO_W-1:0]        quo_y;
	} div_t;

endpackage

/* rtl/segment_intersection_point_unit.sv */
// Intersects two 2-D segments given as signed fixed point coordinates and returns a hit
// flag with the crossing point, or no hit and a zero point for parallel segments or a miss.
// One item is accepted every cycle unless the pipeline holds for the output. In order,
// six stages form the differences, the cross products, the sign-adjusted parameters,
// the hit test and the 96-bit product, then a restoring divider retires one quotient
// bit per stage over 32 stages, and a last stage adds the offset to the start point.
// The whole pipeline holds while a result waits at the output and m_tready is low.
module segment_intersection_point_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// a_start_lon, a_start_lat, a_end_lon, a_end_lat,
	// b_start_lon, b_start_lat, b_end_lon, b_end_lat, zero fill
	input  logic [sip_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// cross_lon, cross_lat, zero fill
	output logic [sip_pkg::OUT_DATA_W-1:0]  m_tdata,
	// hit
	output logic [0:0]                      m_tuser
);
	import sip_pkg::*;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [LON_W-1:0] a0x, a1x, b0x, b1x;
	logic signed [LAT_W-1:0] a0y, a1y, b0y, b1y;
	assign a0x = s_tdata[30:0];
	assign a0y = s_tdata[60:31];
	assign a1x = s_tdata[91:61];
	assign a1y = s_tdata[121:92];
	assign b0x = s_tdata[152:122];
	assign b0y = s_tdata[182:153];
	assign b1x = s_tdata[213:183];
	assign b1y = s_tdata[243:214];

	// Stage 1: direction and offset vectors.
	logic                    v_s1;
	logic signed [LON_W:0]   s1x_s1, s2x_s1, dx_s1;
	logic signed [LAT_W:0]   s1y_s1, s2y_s1, dy_s1;
	logic signed [LON_W-1:0] p0x_s1;
	logic signed [LAT_W-1:0] p0y_s1;

	// Stage 2: the six cross-product terms.
	logic                    v_s2;
	logic signed [PROD_W-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2;
	logic signed [LON_W:0]   s1x_s2;
	logic signed [LAT_W:0]   s1y_s2;
	logic signed [LON_W-1:0] p0x_s2;
	logic signed [LAT_W-1:0] p0y_s2;

	// Stage 3: denominator and numerators.
	logic                     v_s3;
	logic signed [CROSS_W-1:0] d_s3, sn_s3, tn_s3;
	logic signed [LON_W:0]    s1x_s3;
	logic signed [LAT_W:0]    s1y_s3;
	logic signed [LON_W-1:0]  p0x_s3;
	logic signed [LAT_W-1:0]  p0y_s3;

	// Stage 4: signs folded so that the denominator is not negative.
	logic                     v_s4;
	logic signed [CROSS_W-1:0] d_s4, sn_s4, tn_s4;
	logic signed [LON_W:0]    s1x_s4;
	logic signed [LAT_W:0]    s1y_s4;
	logic signed [LON_W-1:0]  p0x_s4;
	logic signed [LAT_W-1:0]  p0y_s4;

	// Stage 5: hit test and partial products of |s1| * tn.
	logic                    v_s5, hit_s5, negx_s5, negy_s5;
	logic [63:0]             pxl_s5;
	logic [62:0]             pxh_s5, pyl_s5;
	logic [61:0]             pyh_s5;
	logic [REM_W-1:0]        d_s5;
	logic signed [LON_W-1:0] p0x_s5;
	logic signed [LAT_W-1:0] p0y_s5;

	logic [LON_W:0]   magx;
	logic [LAT_W:0]   magy;
	logic             hit_c;
	assign magx  = s1x_s4[LON_W] ? (LON_W+1)'(0) - s1x_s4 : s1x_s4;
	assign magy  = s1y_s4[LAT_W] ? (LAT_W+1)'(0) - s1y_s4 : s1y_s4;
	assign hit_c = (d_s4 != '0) && !sn_s4[CROSS_W-1] && (sn_s4 <= d_s4)
		&& !tn_s4[CROSS_W-1] && (tn_s4 <= d_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1x_s1 <= {a1x[LON_W-1], a1x} - {a0x[LON_W-1], a0x};
			s2x_s1 <= {b1x[LON_W-1], b1x} - {b0x[LON_W-1], b0x};
			dx_s1  <= {a0x[LON_W-1], a0x} - {b0x[LON_W-1], b0x};
			s1y_s1 <= {a1y[LAT_W-1], a1y} - {a0y[LAT_W-1], a0y};
			s2y_s1 <= {b1y[LAT_W-1], b1y} - {b0y[LAT_W-1], b0y};
			dy_s1  <= {a0y[LAT_W-1], a0y} - {b0y[LAT_W-1], b0y};
			p0x_s1 <= a0x;
			p0y_s1 <= a0y;

			pa_s2  <= s1x_s1 * s2y_s1;
			pb_s2  <= s2x_s1 * s1y_s1;
			pc_s2  <= s1x_s1 * dy_s1;
			pd_s2  <= s1y_s1 * dx_s1;
			pe_s2  <= s2x_s1 * dy_s1;
			pf_s2  <= s2y_s1 * dx_s1;
			s1x_s2 <= s1x_s1;
			s1y_s2 <= s1y_s1;
			p0x_s2 <= p0x_s1;
			p0y_s2 <= p0y_s1;

			d_s3   <= pa_s2 - pb_s2;
			sn_s3  <= pc_s2 - pd_s2;
			tn_s3  <= pe_s2 - pf_s2;
			s1x_s3 <= s1x_s2;
			s1y_s3 <= s1y_s2;
			p0x_s3 <= p0x_s2;
			p0y_s3 <= p0y_s2;

			d_s4   <= d_s3[CROSS_W-1] ? -d_s3  : d_s3;
			sn_s4  <= d_s3[CROSS_W-1] ? -sn_s3 : sn_s3;
			tn_s4  <= d_s3[CROSS_W-1] ? -tn_s3 : tn_s3;
			s1x_s4 <= s1x_s3;
			s1y_s4 <= s1y_s3;
			p0x_s4 <= p0x_s3;
			p0y_s4 <= p0y_s3;

			hit_s5  <= hit_c;
			negx_s5 <= s1x_s4[LON_W];
			negy_s5 <= s1y_s4[LAT_W];
			pxl_s5  <= magx * tn_s4[31:0];
			pxh_s5  <= magx * tn_s4[62:32];
			pyl_s5  <= magy * tn_s4[31:0];
			pyh_s5  <= magy * tn_s4[62:32];
			d_s5    <= d_s4[REM_W-1:0];
			p0x_s5  <= p0x_s4;
			p0y_s5  <= p0y_s4;
		end
	end

	// Stage 6: full products. As the quotient stays below 2^32, the upper part of
	// each product is already smaller than the denominator and seeds the remainder.
	logic [95:0] prodx, prody;
	assign prodx = {1'b0, pxh_s5, 32'd0} + {32'd0, pxl_s5};
	assign prody = {2'b0, pyh_s5, 32'd0} + {33'd0, pyl_s5};

	div_t div_s [0:DIV_STAGES];
	logic dv_s  [0:DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else if (en) begin
			dv_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].hit   <= hit_s5;
			div_s[0].neg_x <= negx_s5;
			div_s[0].neg_y <= negy_s5;
			div_s[0].p0_x  <= p0x_s5;
			div_s[0].p0_y  <= p0y_s5;
			div_s[0].den   <= d_s5;
			div_s[0].rem_x <= prodx[94:32];
			div_s[0].low_x <= prodx[31:0];
			div_s[0].quo_x <= '0;
			div_s[0].rem_y <= prody[94:32];
			div_s[0].low_y <= prody[31:0];
			div_s[0].quo_y <= '0;
		end
	end

	// One restoring step per stage for each coordinate.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [REM_W:0] rx, ry, dd;
		logic           gx, gy;
		assign dd = {1'b0, div_s[k].den};
		assign rx = {div_s[k].rem_x, div_s[k].low_x[QUO_W-1]};
		assign ry = {div_s[k].rem_y, div_s[k].low_y[QUO_W-1]};
		assign gx = rx >= dd;
		assign gy = ry >= dd;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_s[k+1] <= dv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1].hit   <= div_s[k].hit;
				div_s[k+1].neg_x <= div_s[k].neg_x;
				div_s[k+1].neg_y <= div_s[k].neg_y;
				div_s[k+1].p0_x  <= div_s[k].p0_x;
				div_s[k+1].p0_y  <= div_s[k].p0_y;
				div_s[k+1].den   <= div_s[k].den;
				div_s[k+1].rem_x <= gx ? REM_W'(rx - dd) : rx[REM_W-1:0];
				div_s[k+1].rem_y <= gy ? REM_W'(ry - dd) : ry[REM_W-1:0];
				div_s[k+1].low_x <= {div_s[k].low_x[QUO_W-2:0], 1'b0};
				div_s[k+1].low_y <= {div_s[k].low_y[QUO_W-2:0], 1'b0};
				div_s[k+1].quo_x <= {div_s[k].quo_x[QUO_W-2:0], gx};
				div_s[k+1].quo_y <= {div_s[k].quo_y[QUO_W-2:0], gy};
			end
		end
	end

	div_t            fin;
	logic [QUO_W:0]  bx, by, cx, cy;
	assign fin = div_s[DIV_STAGES];
	assign bx  = {{(QUO_W+1-LON_W){fin.p0_x[LON_W-1]}}, fin.p0_x};
	assign by  = {{(QUO_W+1-LAT_W){fin.p0_y[LAT_W-1]}}, fin.p0_y};
	assign cx  = fin.neg_x ? bx - {1'b0, fin.quo_x} : bx + {1'b0, fin.quo_x};
	assign cy  = fin.neg_y ? by - {1'b0, fin.quo_y} : by + {1'b0, fin.quo_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser <= fin.hit;
			m_tdata <= fin.hit ? {3'b000, cy[LAT_W-1:0], cx[LON_W-1:0]} : '0;
		end
	end

endmodule

/* rtl/sip_checker.sv */
module sip_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [sip_pkg::IN_DATA_W-1:0]   s_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [sip_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [0:0]                      m_tuser
);
	import sip_pkg::*;

	// A result that is held back keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("held result changed");

	// A miss always carries a zero point and zero fill.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("miss with non-zero point");

	// The padding bits above the latitude are never set.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:LON_W+LAT_W] == '0)
		else $error("padding bits set");

	// The input side is ready whenever the output register can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled while output free");

	logic unused_in;
	assign unused_in = s_tvalid ^ (^s_tdata);

endmodule

bind segment_intersection_point_unit sip_checker u_sip_checker (.*);

/* verif/tb.sv */
module tb;
	import sip_pkg::*;

	typedef struct {
		logic                    hit;
		logic signed [LON_W-1:0] lon;
		logic signed [LAT_W-1:0] lat;
	} crossing_t;

	localparam longint LON_MAX = 754974720;
	localparam longint LAT_MAX = 377487360;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0] m_tuser;

	crossing_t expected_crossings[$];
	int mismatches;
	int items_sent;
	int hits_seen;
	int results_seen;
	bit sink_steady;
	bit source_steady;

	segment_intersection_point_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Moves p0 along dir by dir*tn/den, the quotient truncated toward zero.
	function automatic longint walk(longint p0, longint dir, longint tn, longint den);
		logic [127:0] prod;
		logic [127:0] quo;
		longint mag;
		begin
			mag = (dir < 0) ? -dir : dir;
			prod = 128'(mag) * 128'(tn);
			quo = prod / 128'(den);
			walk = (dir < 0) ? p0 - longint'(quo) : p0 + longint'(quo);
		end
	endfunction

	function automatic crossing_t predict_crossing(logic [IN_DATA_W-1:0] data);
		crossing_t r;
		longint p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
		longint s1x, s1y, s2x, s2y, dx, dy, den, sn, tn;
		longint cx, cy;
		begin
			p0x = longint'($signed(data[30:0]));
			p0y = longint'($signed(data[60:31]));
			p1x = longint'($signed(data[91:61]));
			p1y = longint'($signed(data[121:92]));
			p2x = longint'($signed(data[152:122]));
			p2y = longint'($signed(data[182:153]));
			p3x = longint'($signed(data[213:183]));
			p3y = longint'($signed(data[243:214]));
			s1x = p1x - p0x;
			s1y = p1y - p0y;
			s2x = p3x - p2x;
			s2y = p3y - p2y;
			dx = p0x - p2x;
			dy = p0y - p2y;
			den = s1x * s2y - s2x * s1y;
			sn = s1x * dy - s1y * dx;
			tn = s2x * dy - s2y * dx;
			if (den < 0) begin
				den = -den;
				sn = -sn;
				tn = -tn;
			end
			r.hit = 1'b0;
			r.lon = '0;
			r.lat = '0;
			if (den != 0 && sn >= 0 && sn <= den && tn >= 0 && tn <= den) begin
				r.hit = 1'b1;
				cx = walk(p0x, s1x, tn, den);
				cy = walk(p0y, s1y, tn, den);
				r.lon = cx[LON_W-1:0];
				r.lat = cy[LAT_W-1:0];
			end
			predict_crossing = r;
		end
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		begin
			$display("result %0d: %s got %0h expected %0h", results_seen, what, got, want);
			mismatches++;
		end
	endtask

	function automatic logic [IN_DATA_W-1:0] pack_pair(longint c[8]);
		logic [IN_DATA_W-1:0] d;
		begin
			d = '0;
			d[30:0] = c[0][30:0];
			d[60:31] = c[1][29:0];
			d[91:61] = c[2][30:0];
			d[121:92] = c[3][29:0];
			d[152:122] = c[4][30:0];
			d[182:153] = c[5][29:0];
			d[213:183] = c[6][30:0];
			d[243:214] = c[7][29:0];
			pack_pair = d;
		end
	endfunction

	// The item stays on the bus after acceptance; the next call or a drain replaces it.
	task automatic send_pair(longint c[8]);
		logic [IN_DATA_W-1:0] d;
		begin
			d = pack_pair(c);
			while (!source_steady && $urandom_range(99) < 17) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= d;
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			expected_crossings.push_back(predict_crossing(d));
			items_sent++;
		end
	endtask

	function automatic longint rand_coord(bit is_lon);
		longint lim;
		begin
			lim = is_lon ? LON_MAX : LAT_MAX;
			rand_coord = longint'($urandom_range(32'(2 * lim))) - lim;
		end
	endfunction

	// Result checker: one result per accepted item, oldest first.
	always @(posedge clk) begin
		crossing_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_crossings.size() == 0) begin
				report("unexpected result", m_tdata, 64'd0);
			end else begin
				want = expected_crossings.pop_front();
				if (m_tuser[0] !== want.hit)
					report("hit", 64'(m_tuser[0]), 64'(want.hit));
				if (m_tdata[30:0] !== want.lon)
					report("cross_lon", 64'(m_tdata[30:0]), 64'(want.lon));
				if (m_tdata[60:31] !== want.lat)
					report("cross_lat", 64'(m_tdata[60:31]), 64'(want.lat));
				if (m_tdata[63:61] !== 3'b000)
					report("fill", 64'(m_tdata[63:61]), 64'd0);
				hits_seen += want.hit;
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (sink_steady)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(99) >= 17);
	end

	task automatic wait_drained();
		begin
			s_tvalid <= 1'b0;
			while (expected_crossings.size() != 0)
				@(posedge clk);
		end
	endtask

	task automatic test_extremes();
		longint c[8];
		begin
			// Corners of the coordinate range in every combination of signs.
			c = '{-LON_MAX, -LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, -LAT_MAX};
			send_pair(c);
			c = '{LON_MAX, LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, LAT_MAX};
			send_pair(c);
			c = '{-LON_MAX, -LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX, -LAT_MAX};
			send_pair(c);
			c = '{LON_MAX, LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, LAT_MAX};
			send_pair(c);
			c = '{0, 0, 0, 0, 0, 0, 0, 0};
			send_pair(c);
			// Every bit pattern is accepted, so the raw field extremes go through too.
			c = '{-(1 << 30), -(1 << 29), (1 << 30) - 1, (1 << 29) - 1,
				(1 << 30) - 1, -(1 << 29), -(1 << 30), (1 << 29) - 1};
			send_pair(c);
			c = '{-1, -1, -1, -1, -1, -1, -1, -1};
			send_pair(c);
		end
	endtask

	task automatic test_special_cases();
		longint c[8];
		begin
			// Parallel segments give a zero denominator.
			c = '{0, 0, 1000, 1000, 0, 10, 1000, 1010};
			send_pair(c);
			// Collinear overlapping segments.
			c = '{0, 0, 1000, 0, 500, 0, 1500, 0};
			send_pair(c);
			// Miss: lines cross beyond the end of one segment.
			c = '{0, 0, 100, 0, 200, -50, 200, 50};
			send_pair(c);
			// Touch at an end point, so a parameter is exactly one.
			c = '{0, 0, 100, 0, 100, -50, 100, 50};
			send_pair(c);
			// Touch at a start point, so a parameter is exactly zero.
			c = '{0, 0, 100, 0, 0, -50, 0, 50};
			send_pair(c);
			// Crossing with an inexact quotient in negative directions.
			c = '{1000, 1000, -7, -3, -300, 900, 800, -11};
			send_pair(c);
			c = '{-5, 7, 3, -9, -8, -4, 6, 5};
			send_pair(c);
			// A degenerate zero-length segment.
			c = '{10, 10, 10, 10, 0, 0, 20, 20};
			send_pair(c);
		end
	endtask

	task automatic test_random(int count);
		longint c[8];
		longint cx, cy, span;
		int n;
		begin
			for (n = 0; n < count; n++) begin
				if ($urandom_range(9) < 6) begin
					// Segments through a common point, mostly hits.
					span = (n % 3 == 0) ? 1000 : LAT_MAX / 2;
					cx = rand_coord(1'b1) / 2;
					cy = rand_coord(1'b0) / 2;
					c[0] = cx - longint'($urandom_range(32'(span)));
					c[1] = cy - longint'($urandom_range(32'(span)));
					c[2] = cx + longint'($urandom_range(32'(span)));
					c[3] = cy + longint'($urandom_range(32'(span)));
					c[4] = cx + longint'($urandom_range(32'(span)));
					c[5] = cy - longint'($urandom_range(32'(span)));
					c[6] = cx - longint'($urandom_range(32'(span)));
					c[7] = cy + longint'($urandom_range(32'(span)));
					if ($urandom_range(1)) begin
						span = c[0]; c[0] = c[2]; c[2] = span;
						span = c[1]; c[1] = c[3]; c[3] = span;
					end
				end else if ($urandom_range(3) == 0) begin
					// Raw bit patterns across the whole field width.
					for (int k = 0; k < 8; k++)
						c[k] = longint'($signed(32'($urandom()) << 1)) >>> 1;
				end else begin
					for (int k = 0; k < 8; k++)
						c[k] = rand_coord(k % 2 == 0);
				end
				send_pair(c);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		sink_steady = 1'b0;
		source_steady = 1'b0;
		mismatches = 0;
		items_sent = 0;
		hits_seen = 0;
		results_seen = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_special_cases();
		// The sender holds off until the pipeline has fully drained.
		wait_drained();
		test_random(500);
		sink_steady = 1'b1;
		source_steady = 1'b1;
		test_random(300);
		sink_steady = 1'b0;
		source_steady = 1'b0;
		test_random(300);
		wait_drained();
		repeat (50) @(posedge clk);
		$display("Sent %0d segment pairs, %0d results checked, %0d of them crossings.",
			items_sent, results_seen, hits_seen);
		if (mismatches == 0 && expected_crossings.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out waiting for results.");
		$display("Mismatches found");
		$finish;
	end

endmodule
